/* hw/rtl/min_max_mode_of_set_core_defines.svh */
// ----------------------------------------------------------------------------
// min_max_mode_of_set_core_defines.svh
// Assertion macros used by the checker of the min/max/mode core.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_MODE_OF_SET_CORE_DEFINES_SVH
`define MIN_MAX_MODE_OF_SET_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MMMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MMMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mmms_pkg.sv */
// ----------------------------------------------------------------------------
// mmms_pkg
// Shared sizes, types and helpers of the min/max/mode core.
// ----------------------------------------------------------------------------
package mmms_pkg;

	// Number of values one set can hold
	localparam int CAPACITY = 16;
	// Store address width
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	// Width of a count that can reach CAPACITY
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int OCC_W    = 5;
	localparam int OCC_MAX  = 31;

	// Write port of the value store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} mmms_wr_t;

	// Clamp an occurrence count to the result field
	function automatic logic [OCC_W-1:0] sat_count(input logic [CNT_W-1:0] c);
		logic [CNT_W+OCC_W-1:0] w;
		w = (CNT_W+OCC_W)'(c);
		if (w > (CNT_W+OCC_W)'(OCC_MAX)) begin
			return OCC_W'(OCC_MAX);
		end else begin
			return w[OCC_W-1:0];
		end
	endfunction

endpackage

/* hw/rtl/mmms_store.sv */
// ----------------------------------------------------------------------------
// mmms_store
// Value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmms_store (
	input  logic                          clk,
	input  mmms_pkg::mmms_wr_t            wr,
	input  logic [mmms_pkg::IDX_W-1:0]    rd_addr,
	output logic [mmms_pkg::VAL_W-1:0]    rd_data_s1
);

	logic [mmms_pkg::VAL_W-1:0] mem [mmms_pkg::CAPACITY];

	// Write and synchronous read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

endmodule

/* hw/rtl/min_max_mode_of_set_core.sv */
// ----------------------------------------------------------------------------
// min_max_mode_of_set_core
// Smallest, greatest and most frequent value of a set of signed words.
// ----------------------------------------------------------------------------
// A set arrives one word per cycle on the input channel while in_stall is
// low, the last word flagged by final_item; up to CAPACITY words are kept in
// a store with one write and one read port, later ones only raise dropped.
// Smallest and greatest are tracked as words load. After the final word the
// core stalls its input and, for each stored word i, reads word i and then
// sweeps the store once to count its copies, one word at a time through the
// one read port of the store, before the result word enters the output
// register. The mode is the word with the highest count, a tie going to the
// larger word. The result word waits in the output register while the next
// set loads.
module min_max_mode_of_set_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] sample,
	input  logic               final_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] smallest,
	output logic signed [31:0] greatest,
	output logic signed [31:0] mode_value,
	output logic [4:0]         mode_count,
	output logic               dropped
);

	localparam int IDX_W = mmms_pkg::IDX_W;
	localparam int CNT_W = mmms_pkg::CNT_W;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FETCH  = 6'b000010,
		ST_HOLD   = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         fill_q;
	logic                     overflow_q;
	logic [IDX_W-1:0]         i_q;
	logic [IDX_W-1:0]         k_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_nxt;
	logic [CNT_W-1:0]         mode_c_q;
	logic signed [31:0]       mode_v_q;
	logic signed [31:0]       lo_q;
	logic signed [31:0]       hi_q;
	logic signed [31:0]       vi_q;
	logic                     rd_vld_s1;
	logic [31:0]              rd_data_s1;
	logic [IDX_W-1:0]         rd_addr;
	mmms_pkg::mmms_wr_t       wr;
	logic                     in_acc;
	logic                     has_room;
	logic                     k_last;
	logic                     i_last;
	logic                     out_free;
	logic                     match;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign has_room = (fill_q < CNT_W'(mmms_pkg::CAPACITY));
	assign k_last   = ((CNT_W'(k_q) + CNT_W'(1)) == fill_q);
	assign i_last   = ((CNT_W'(i_q) + CNT_W'(1)) == fill_q);
	assign out_free = !out_valid || !out_stall;
	assign match    = rd_vld_s1 && (rd_data_s1 == vi_q);
	assign cnt_nxt  = cnt_q + CNT_W'(match);

	// Store access: writes only while loading; read address is i_q in FETCH, else k_q
	assign wr.en   = in_acc && has_room;
	assign wr.addr = fill_q[IDX_W-1:0];
	assign wr.data = sample;
	assign rd_addr = (state_q == ST_FETCH) ? i_q : k_q;

	mmms_store u_store (
		.clk        (clk),
		.wr         (wr),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_data_s1)
	);

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			overflow_q <= 1'b0;
			i_q        <= '0;
			k_q        <= '0;
			cnt_q      <= '0;
			mode_c_q   <= '0;
			rd_vld_s1  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			cnt_q     <= cnt_nxt;
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (has_room) begin
							fill_q <= fill_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (final_item) begin
							i_q     <= '0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					cnt_q   <= '0;
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					k_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_vld_s1 <= 1'b1;
					k_q       <= k_q + IDX_W'(1);
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last compare lands here; fold the count into the mode
					if ((cnt_nxt > mode_c_q) || ((cnt_nxt == mode_c_q) && (vi_q > mode_v_q))) begin
						mode_c_q <= cnt_nxt;
					end
					cnt_q <= '0;
					i_q   <= i_q + IDX_W'(1);
					if (i_last) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						fill_q     <= '0;
						overflow_q <= 1'b0;
						mode_c_q   <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// running extremes over stored words
		if (wr.en) begin
			if (fill_q == '0) begin
				lo_q <= sample;
				hi_q <= sample;
			end else begin
				if (sample < lo_q) begin
					lo_q <= sample;
				end
				if (sample > hi_q) begin
					hi_q <= sample;
				end
			end
		end
		// candidate word under count
		if (state_q == ST_HOLD) begin
			vi_q <= rd_data_s1;
		end
		if ((state_q == ST_DRAIN) &&
		    ((cnt_nxt > mode_c_q) || ((cnt_nxt == mode_c_q) && (vi_q > mode_v_q)))) begin
			mode_v_q <= vi_q;
		end
		// result word
		if ((state_q == ST_FINISH) && out_free) begin
			smallest   <= lo_q;
			greatest   <= hi_q;
			mode_value <= mode_v_q;
			mode_count <= mmms_pkg::sat_count(mode_c_q);
			dropped    <= overflow_q;
		end
	end

endmodule

/* hw/rtl/mmms_checker.sv */
// ----------------------------------------------------------------------------
// mmms_checker
// Port-level checks of the min/max/mode core, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_max_mode_of_set_core_defines.svh"

module mmms_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic signed [31:0] sample,
	input logic               final_item,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] smallest,
	input logic signed [31:0] greatest,
	input logic signed [31:0] mode_value,
	input logic [4:0]         mode_count,
	input logic               dropped
);

	// stalled result word holds
	`MMMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(smallest) && $stable(greatest) && $stable(mode_value) && $stable(mode_count) && $stable(dropped), "result word changed under stall")

	// the end of a set closes the input while counting
	`MMMS_ASSERT_NEXT(a_final_stalls, in_valid && !in_stall && final_item, in_stall, "input open right after final word")

	// a result only appears after a counting pass
	`MMMS_ASSERT_NOW(a_result_after_count, $rose(out_valid), $past(in_stall), "result without counting pass")

	// result word is self-consistent
	`MMMS_ASSERT_NOW(a_result_sane, out_valid, (mode_count != 5'd0) && (smallest <= greatest) && (mode_value >= smallest) && (mode_value <= greatest), "inconsistent result word")

endmodule

bind min_max_mode_of_set_core mmms_checker u_mmms_checker (.*);

/* tb/min_max_mode_of_set_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_max_mode_of_set_core_tb
// Self-checking bench for the min/max/mode core.
// ----------------------------------------------------------------------------
// Sets of signed words go into the core with random gaps. A scoreboard keeps
// its own copy of the stored set and works out smallest, greatest, mode and
// overflow on each final word. Result words are drained with random stalls,
// including one long hold-off that backs the core up into its input, and are
// compared field by field in order.
// ----------------------------------------------------------------------------
module min_max_mode_of_set_core_tb;
	localparam int CAPACITY = mmms_pkg::CAPACITY;
	localparam int VAL_W    = mmms_pkg::VAL_W;
	localparam int OCC_W    = mmms_pkg::OCC_W;
	localparam int OCC_MAX  = mmms_pkg::OCC_MAX;

	localparam int TOTAL_WORDS = 1000;
	localparam int HOLD_CYCLES = 400;
	// Worst compute time of a full store plus margin
	localparam int DRAIN_CYCLES = CAPACITY * (CAPACITY + 3) + 100;

	localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};

	// Value styles for random sets
	typedef enum int {
		STYLE_SPREAD,
		STYLE_POOL,
		STYLE_EXTREME,
		STYLE_SAME
	} set_style_t;

	typedef struct {
		logic signed [VAL_W-1:0] smallest;
		logic signed [VAL_W-1:0] greatest;
		logic signed [VAL_W-1:0] mode_value;
		logic [OCC_W-1:0]        mode_count;
		logic                    dropped;
	} set_summary_t;

	// Tracks the set being loaded and the summaries still owed by the core
	class set_scoreboard;
		logic signed [VAL_W-1:0] held[$];
		bit                      overflowed;
		set_summary_t            owed[$];
		int                      errors;
		int                      sets_closed;
		int                      sets_overflowed;
		int                      results_seen;

		task report(input string msg);
			errors++;
			$display("MISMATCH at result %0d: %s", results_seen, msg);
		endtask

		// Accepted input word; closes the set when last is high
		function void note_word(input logic signed [VAL_W-1:0] v, input logic last);
			set_summary_t s;
			int copies;
			int best;
			if (held.size() < CAPACITY)
				held.push_back(v);
			else
				overflowed = 1'b1;
			if (!last)
				return;
			s.smallest   = held[0];
			s.greatest   = held[0];
			s.mode_value = held[0];
			best = 0;
			foreach (held[i]) begin
				copies = 0;
				foreach (held[k])
					if (held[k] == held[i])
						copies++;
				if (held[i] < s.smallest)
					s.smallest = held[i];
				if (held[i] > s.greatest)
					s.greatest = held[i];
				// ties go to the larger value
				if (copies > best || (copies == best && held[i] > s.mode_value)) begin
					best = copies;
					s.mode_value = held[i];
				end
			end
			s.mode_count = (best > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(best);
			s.dropped = overflowed;
			owed.push_back(s);
			sets_closed++;
			if (overflowed)
				sets_overflowed++;
			held.delete();
			overflowed = 1'b0;
		endfunction

		// Accepted result word against the oldest owed summary
		task check_result(input logic signed [VAL_W-1:0] got_min,
				input logic signed [VAL_W-1:0] got_max,
				input logic signed [VAL_W-1:0] got_mode,
				input logic [OCC_W-1:0] got_count, input logic got_dropped);
			set_summary_t want;
			results_seen++;
			if (owed.size() == 0) begin
				report("result word with no set closed");
				return;
			end
			want = owed.pop_front();
			if (got_min !== want.smallest)
				report($sformatf("smallest %0d, want %0d", got_min, want.smallest));
			if (got_max !== want.greatest)
				report($sformatf("greatest %0d, want %0d", got_max, want.greatest));
			if (got_mode !== want.mode_value)
				report($sformatf("mode_value %0d, want %0d", got_mode, want.mode_value));
			if (got_count !== want.mode_count)
				report($sformatf("mode_count %0d, want %0d", got_count, want.mode_count));
			if (got_dropped !== want.dropped)
				report($sformatf("dropped %0b, want %0b", got_dropped, want.dropped));
		endtask
	endclass

	logic                    clk;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic                    in_stall;
	logic signed [VAL_W-1:0] sample     = '0;
	logic                    final_item = 1'b0;
	logic                    out_valid;
	logic                    out_stall  = 1'b0;
	logic signed [VAL_W-1:0] smallest;
	logic signed [VAL_W-1:0] greatest;
	logic signed [VAL_W-1:0] mode_value;
	logic [OCC_W-1:0]        mode_count;
	logic                    dropped;

	set_scoreboard book = new();

	int   words_sent = 0;
	logic hold_rx    = 1'b0;
	bit   tx_burst   = 1'b0;

	min_max_mode_of_set_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.final_item (final_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.smallest   (smallest),
		.greatest   (greatest),
		.mode_value (mode_value),
		.mode_count (mode_count),
		.dropped    (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle cycles before the next word: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (tx_burst || hold_rx)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 30);
	endfunction

	// Offer one word and hold it until the core takes it
	task send_word(input logic signed [VAL_W-1:0] v, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		sample     <= v;
		final_item <= last;
		do
			@(posedge clk);
		while (in_stall);
		book.note_word(v, last);
		words_sent++;
	endtask

	// One random set: length and value style drawn per set
	task send_random_set();
		logic signed [VAL_W-1:0] pool[4];
		logic signed [VAL_W-1:0] v;
		set_style_t style;
		int len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			len = $urandom_range(1, 6);
		else if (r < 85)
			len = $urandom_range(7, CAPACITY);
		else if (r < 93)
			len = CAPACITY;
		else
			len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
		style = set_style_t'($urandom_range(0, 3));
		foreach (pool[i])
			pool[i] = ($urandom_range(0, 1) != 0) ? $urandom : $signed($urandom_range(0, 6)) - 3;
		for (int n = 0; n < len; n++) begin
			case (style)
				STYLE_SPREAD: v = $urandom;
				STYLE_POOL: v = pool[$urandom_range(0, 3)];
				STYLE_EXTREME: begin
					case ($urandom_range(0, 5))
						0: v = MOST_NEG;
						1: v = MOST_POS;
						2: v = MOST_NEG + 1;
						3: v = MOST_POS - 1;
						4: v = -1;
						default: v = 0;
					endcase
				end
				default: v = pool[0];
			endcase
			send_word(v, n == len - 1);
		end
	endtask

	// Stimulus: directed sets, then random sets
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single-word sets at both ends of the range
		send_word(MOST_NEG, 1'b1);
		send_word(MOST_POS, 1'b1);
		// tie for the mode between -1 and 3, larger wins
		send_word(-1, 1'b0);
		send_word(3, 1'b0);
		send_word(-1, 1'b0);
		send_word(3, 1'b0);
		send_word(0, 1'b1);
		// full store of alternating extremes, then dropped words incl. the final one
		for (int i = 0; i < CAPACITY + 2; i++)
			send_word((i < CAPACITY) ? ((i % 2) ? MOST_POS : MOST_NEG) : 0,
				i == CAPACITY + 1);

		while (words_sent < TOTAL_WORDS) begin
			if ($urandom_range(0, 3) == 0)
				tx_burst = ~tx_burst;
			send_random_set();
		end
		in_valid <= 1'b0;

		while (book.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d words in %0d sets, %0d of them past the %0d-word store.",
			words_sent, book.sets_closed, book.sets_overflowed, CAPACITY);
		$display("Checked %0d result words, with random output stalls and a %0d-cycle hold-off.",
			book.results_seen, HOLD_CYCLES);
		if (book.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Long output hold-off so the core fills up and stalls its input
	initial begin
		wait (words_sent >= 300);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// Result side: check accepted words, then pick the next stall
	initial begin
		int stall_left;
		int cyc;
		bit rx_free;
		int r;
		stall_left = 0;
		cyc = 0;
		rx_free = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				book.check_result(smallest, greatest, mode_value, mode_count, dropped);
			cyc++;
			if (cyc % 200 == 0)
				rx_free = ($urandom_range(0, 3) == 0);
			if (hold_rx) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (rx_free) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_stall <= 1'b0;
				end else if (r < 92) begin
					stall_left = $urandom_range(0, 2);
					out_stall <= 1'b1;
				end else begin
					stall_left = $urandom_range(15, 50);
					out_stall <= 1'b1;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mmms_pkg.sv
hw/rtl/mmms_store.sv
hw/rtl/min_max_mode_of_set_core.sv
hw/rtl/mmms_checker.sv
tb/min_max_mode_of_set_core_tb.sv
